### hdl/rrsp_pkg.sv
`timescale 1ns / 1ps
package rrsp_pkg;

	localparam int MAX_DEPTH = 32;
	localparam int IDX_W = $clog2(MAX_DEPTH);
	localparam int DEPTH_W = 6;
	localparam int LINE_MAX = 65536;
	localparam int LLEN_W = $clog2(LINE_MAX) + 1;
	localparam int FREM_W = 33;
	localparam int RB_W = 33;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW = $clog2(FIFO_DEPTH);

	localparam logic [RB_W-1:0] REPLY_SAT = {RB_W{1'b1}};
	localparam logic [67:0] MAG_LIMIT = 68'h0_8000_0000_0000_0000;

	// stream characters
	localparam logic [7:0] CH_PLUS = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_HASH = 8'h23;
	localparam logic [7:0] CH_UNDER = 8'h5F;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_BANG = 8'h21;
	localparam logic [7:0] CH_EQUAL = 8'h3D;
	localparam logic [7:0] CH_STAR = 8'h2A;
	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_TILDE = 8'h7E;
	localparam logic [7:0] CH_GT = 8'h3E;
	localparam logic [7:0] CH_PIPE = 8'h7C;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_0 = 8'h30;
	localparam logic [7:0] CH_9 = 8'h39;
	localparam logic [7:0] CH_T = 8'h74;
	localparam logic [7:0] CH_F = 8'h66;

	// value kinds
	localparam logic [3:0] VK_SIMPLE = 4'd0;
	localparam logic [3:0] VK_ERROR = 4'd1;
	localparam logic [3:0] VK_INT = 4'd2;
	localparam logic [3:0] VK_BIGNUM = 4'd3;
	localparam logic [3:0] VK_DOUBLE = 4'd4;
	localparam logic [3:0] VK_BOOL = 4'd5;
	localparam logic [3:0] VK_NULL = 4'd6;
	localparam logic [3:0] VK_BULK = 4'd7;
	localparam logic [3:0] VK_BLOBERR = 4'd8;
	localparam logic [3:0] VK_VERB = 4'd9;
	localparam logic [3:0] VK_ARRAY = 4'd10;
	localparam logic [3:0] VK_MAP = 4'd11;
	localparam logic [3:0] VK_SET = 4'd12;
	localparam logic [3:0] VK_PUSH = 4'd13;
	localparam logic [3:0] VK_ATTR = 4'd14;
	localparam logic [3:0] VK_UNKNOWN = 4'd15;

	localparam logic [2:0] FT_PUSH = 3'd3;
	localparam logic [2:0] FT_ATTR = 3'd4;

	// event kinds
	localparam logic [1:0] EV_PAYLOAD = 2'd0;
	localparam logic [1:0] EV_COMPLETE = 2'd1;
	localparam logic [1:0] EV_OPEN = 2'd2;
	localparam logic [1:0] EV_ERROR = 2'd3;

	// error codes
	localparam logic [3:0] ERR_LINE = 4'd0;
	localparam logic [3:0] ERR_INT = 4'd1;
	localparam logic [3:0] ERR_BIGNUM = 4'd2;
	localparam logic [3:0] ERR_DOUBLE = 4'd3;
	localparam logic [3:0] ERR_BOOL = 4'd4;
	localparam logic [3:0] ERR_NULL = 4'd5;
	localparam logic [3:0] ERR_LENGTH = 4'd6;
	localparam logic [3:0] ERR_BULK = 4'd7;
	localparam logic [3:0] ERR_CRLF = 4'd8;
	localparam logic [3:0] ERR_VERB = 4'd9;
	localparam logic [3:0] ERR_ELEMS = 4'd10;
	localparam logic [3:0] ERR_DEPTH = 4'd11;
	localparam logic [3:0] ERR_REPLY = 4'd12;
	localparam logic [3:0] ERR_TYPE = 4'd13;
	localparam logic [3:0] ERR_FAILED = 4'd14;

	// register indexes
	localparam logic [1:0] REG_BULK = 2'd0;
	localparam logic [1:0] REG_ELEMS = 2'd1;
	localparam logic [1:0] REG_DEPTH = 2'd2;
	localparam logic [1:0] REG_REPLY = 2'd3;

	typedef enum logic [2:0] {
		PH_TYPE,
		PH_LINE,
		PH_DATA,
		PH_DCR,
		PH_DLF
	} phase_t;

	typedef enum logic {
		BK_BYTE,
		BK_SETTLE
	} back_state_t;

	typedef struct packed {
		logic [29:0] bulk_limit;
		logic [31:0] element_limit;
		logic [5:0] depth_limit;
		logic [31:0] reply_limit;
	} cfg_t;

	typedef struct packed {
		logic [7:0] data;
		logic [3:0] kind;
	} item_t;

endpackage

### hdl/rrsp_front.sv
`timescale 1ns / 1ps
module rrsp_front (
	input logic clk,
	input logic arst_n,
	input logic byte_valid,
	output logic byte_stall,
	input logic [7:0] data_byte,
	output logic item_valid,
	output rrsp_pkg::item_t item,
	input logic item_pop
);
	import rrsp_pkg::*;

	item_t fifo_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q;
	logic [FIFO_AW-1:0] rd_ptr_q;
	logic [FIFO_AW:0] count_q;
	logic push;
	logic pop;
	logic [3:0] kind;

	always_comb begin
		unique case (data_byte)
			CH_PLUS: kind = VK_SIMPLE;
			CH_MINUS: kind = VK_ERROR;
			CH_COLON: kind = VK_INT;
			CH_LPAREN: kind = VK_BIGNUM;
			CH_COMMA: kind = VK_DOUBLE;
			CH_HASH: kind = VK_BOOL;
			CH_UNDER: kind = VK_NULL;
			CH_DOLLAR: kind = VK_BULK;
			CH_BANG: kind = VK_BLOBERR;
			CH_EQUAL: kind = VK_VERB;
			CH_STAR: kind = VK_ARRAY;
			CH_PERCENT: kind = VK_MAP;
			CH_TILDE: kind = VK_SET;
			CH_GT: kind = VK_PUSH;
			CH_PIPE: kind = VK_ATTR;
			default: kind = VK_UNKNOWN;
		endcase
	end

	assign byte_stall = (count_q == (FIFO_AW+1)'(FIFO_DEPTH));
	assign push = byte_valid && !byte_stall;
	assign item_valid = (count_q != '0);
	assign pop = item_pop && item_valid;
	assign item = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= '{data: data_byte, kind: kind};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### hdl/rrsp_back.sv
`timescale 1ns / 1ps
module rrsp_back (
	input logic clk,
	input logic arst_n,
	input rrsp_pkg::cfg_t cfg,
	input logic item_valid,
	input rrsp_pkg::item_t item,
	output logic item_pop,
	output logic event_valid,
	input logic event_stall,
	output logic [1:0] event_kind,
	output logic [3:0] value_kind,
	output logic [7:0] payload,
	output logic [63:0] number,
	output logic [5:0] depth,
	output logic [5:0] levels_closed,
	output logic reply_done,
	output logic discarded,
	output logic [3:0] error_code
);
	import rrsp_pkg::*;

	typedef struct packed {
		logic [63:0] acc;
		logic neg;
		logic digit;
		logic bad;
	} num_st_t;

	function automatic num_st_t numeric_char(input num_st_t s, input logic [3:0] k,
			input logic [LLEN_W-1:0] llen, input logic [7:0] c);
		num_st_t r;
		logic [67:0] prod;
		r = s;
		prod = ({4'b0, s.acc} << 3) + ({4'b0, s.acc} << 1) + {60'b0, c - CH_0};
		if (k == VK_BOOL) begin
			if (llen == '0) begin
				r.acc = {56'b0, c};
			end else begin
				r.bad = 1'b1;
			end
		end else if (k == VK_NULL) begin
			r.bad = 1'b1;
		end else if (k == VK_UNKNOWN) begin
			r = s;
		end else if (llen == '0 && c == CH_MINUS) begin
			r.neg = 1'b1;
		end else if (c >= CH_0 && c <= CH_9) begin
			r.digit = 1'b1;
			if (!s.bad) begin
				if (prod > MAG_LIMIT) begin
					r.bad = 1'b1;
				end else begin
					r.acc = prod[63:0];
				end
			end
		end else begin
			r.bad = 1'b1;
		end
		return r;
	endfunction

	back_state_t state_q, n_state;
	phase_t phase_q, n_phase;
	logic [3:0] ctype_q, n_ctype;
	logic [LLEN_W-1:0] llen_q, n_llen;
	logic [63:0] acc_q, n_acc;
	logic neg_q, digit_q, bad_q, held_q;
	logic n_neg, n_digit, n_bad, n_held;
	logic [29:0] brem_q, n_brem;
	logic [DEPTH_W-1:0] depth_q, n_depth;
	logic [RB_W-1:0] rbytes_q, n_rb;
	logic failed_q, n_failed;
	logic deliver_q, n_deliver;
	logic [FREM_W-1:0] frem_q [MAX_DEPTH];
	logic [2:0] ftype_q [MAX_DEPTH];

	logic ev_valid_q, n_ev_valid;
	logic [1:0] ev_kind_q, n_ev_kind;
	logic [3:0] vk_q, n_vk;
	logic [7:0] pay_q, n_pay;
	logic [63:0] num_q, n_num;
	logic [5:0] dep_q, n_dep;
	logic [5:0] closed_q, n_closed;
	logic done_q, n_done;
	logic disc_q, n_disc;
	logic [3:0] err_q, n_err;

	logic fr_we;
	logic [IDX_W-1:0] fr_addr;
	logic [FREM_W-1:0] fr_rem;
	logic ft_we;
	logic [2:0] ft_type;

	logic take;
	logic settle_go;
	logic settle_end;
	logic in_disc;
	logic [MAX_DEPTH-1:0] attr_live;
	logic [IDX_W-1:0] top;
	logic [DEPTH_W-1:0] top_full;
	logic [FREM_W-1:0] rem_eff;

	assign take = (state_q == BK_BYTE) && item_valid && (!ev_valid_q || !event_stall);
	assign item_pop = take;

	always_comb begin
		for (int i = 0; i < MAX_DEPTH; i++) begin
			attr_live[i] = (DEPTH_W'(i) < depth_q) && (ftype_q[i] == FT_ATTR);
		end
	end
	assign in_disc = (|attr_live) || (depth_q != '0 && ftype_q[0] == FT_PUSH);

	assign top_full = depth_q - 1'b1;
	assign top = top_full[IDX_W-1:0];
	assign rem_eff = (deliver_q && frem_q[top] != '0) ? frem_q[top] - 1'b1 : frem_q[top];
	assign settle_end = (state_q == BK_SETTLE) && (depth_q == '0 || rem_eff != '0);

	// state sequencing
	always_comb begin
		n_state = state_q;
		unique case (state_q)
			BK_BYTE: begin
				if (settle_go) begin
					n_state = BK_SETTLE;
				end
			end
			BK_SETTLE: begin
				if (settle_end) begin
					n_state = BK_BYTE;
				end
			end
			default: n_state = BK_BYTE;
		endcase
	end

	// datapath
	always_comb begin
		logic [7:0] b;
		logic is_text;
		logic ok;
		logic [LLEN_W-1:0] l1;
		num_st_t s;
		logic [63:0] n64;
		logic [DEPTH_W-1:0] eff;
		logic [DEPTH_W-1:0] nd;
		logic [2:0] t;
		logic do_fail, do_finish, do_open, ev_go;
		logic [3:0] f_code, fin_vk;
		logic [63:0] fin_num;

		b = item.data;
		is_text = (ctype_q == VK_SIMPLE) || (ctype_q == VK_ERROR)
			|| (ctype_q == VK_BIGNUM) || (ctype_q == VK_DOUBLE);
		ok = !bad_q && digit_q && !(!neg_q && acc_q == MAG_LIMIT[63:0]);
		n64 = (ctype_q == VK_MAP || ctype_q == VK_ATTR) ? {acc_q[62:0], 1'b0} : acc_q;
		eff = (cfg.depth_limit < DEPTH_W'(MAX_DEPTH)) ? cfg.depth_limit : DEPTH_W'(MAX_DEPTH);
		l1 = llen_q;
		s = '{acc: acc_q, neg: neg_q, digit: digit_q, bad: bad_q};
		nd = depth_q - 1'b1;
		t = ftype_q[top];
		do_fail = 1'b0;
		do_finish = 1'b0;
		do_open = 1'b0;
		ev_go = 1'b0;
		f_code = ERR_FAILED;
		fin_vk = ctype_q;
		fin_num = '0;

		n_phase = phase_q;
		n_ctype = ctype_q;
		n_llen = llen_q;
		n_acc = acc_q;
		n_neg = neg_q;
		n_digit = digit_q;
		n_bad = bad_q;
		n_held = held_q;
		n_brem = brem_q;
		n_depth = depth_q;
		n_rb = rbytes_q;
		n_failed = failed_q;
		n_deliver = deliver_q;
		settle_go = 1'b0;
		fr_we = 1'b0;
		fr_addr = top;
		fr_rem = rem_eff;
		ft_we = 1'b0;
		ft_type = ctype_q[2:0] - VK_ARRAY[2:0];

		n_ev_valid = ev_valid_q && event_stall;
		n_ev_kind = ev_kind_q;
		n_vk = vk_q;
		n_pay = pay_q;
		n_num = num_q;
		n_dep = dep_q;
		n_closed = closed_q;
		n_done = done_q;
		n_disc = disc_q;
		n_err = err_q;

		if (state_q == BK_SETTLE) begin
			// one stack level per cycle
			if (depth_q == '0) begin
				if (deliver_q) begin
					n_done = 1'b1;
					n_rb = '0;
				end
				n_ev_valid = 1'b1;
			end else if (rem_eff != '0) begin
				fr_we = 1'b1;
				n_ev_valid = 1'b1;
			end else begin
				n_depth = nd;
				n_closed = closed_q + 1'b1;
				n_deliver = !(t == FT_ATTR) && !(t == FT_PUSH && nd == '0);
				if (t == FT_PUSH && nd == '0) begin
					n_rb = '0;
				end
			end
		end else if (take) begin
			if (failed_q) begin
				do_fail = 1'b1;
			end else begin
				n_rb = (rbytes_q < REPLY_SAT) ? rbytes_q + 1'b1 : rbytes_q;
				unique case (phase_q)
					PH_TYPE: begin
						n_ctype = item.kind;
						n_llen = '0;
						n_acc = '0;
						n_neg = 1'b0;
						n_digit = 1'b0;
						n_bad = 1'b0;
						n_held = 1'b0;
						n_phase = PH_LINE;
					end
					PH_LINE: begin
						if (held_q && b == CH_LF && (!is_text || acc_q[7:0] == CH_CR)) begin
							unique case (ctype_q) inside
								VK_SIMPLE, VK_ERROR: do_finish = 1'b1;
								VK_INT: begin
									if (!ok) begin
										do_fail = 1'b1;
										f_code = ERR_INT;
									end else begin
										do_finish = 1'b1;
										fin_num = neg_q ? (64'd0 - acc_q) : acc_q;
									end
								end
								VK_BIGNUM: begin
									if (bad_q || !digit_q) begin
										do_fail = 1'b1;
										f_code = ERR_BIGNUM;
									end else begin
										do_finish = 1'b1;
									end
								end
								VK_DOUBLE: begin
									if (llen_q == '0) begin
										do_fail = 1'b1;
										f_code = ERR_DOUBLE;
									end else begin
										do_finish = 1'b1;
									end
								end
								VK_BOOL: begin
									if (llen_q != LLEN_W'(1)
											|| (acc_q != {56'b0, CH_T} && acc_q != {56'b0, CH_F})) begin
										do_fail = 1'b1;
										f_code = ERR_BOOL;
									end else begin
										do_finish = 1'b1;
										fin_num = {63'b0, acc_q == {56'b0, CH_T}};
									end
								end
								VK_NULL: begin
									if (llen_q != '0) begin
										do_fail = 1'b1;
										f_code = ERR_NULL;
									end else begin
										do_finish = 1'b1;
									end
								end
								VK_BULK, VK_BLOBERR, VK_VERB: begin
									if (!ok) begin
										do_fail = 1'b1;
										f_code = ERR_LENGTH;
									end else if (ctype_q == VK_BULK && neg_q && acc_q == 64'd1) begin
										do_finish = 1'b1;
										fin_vk = VK_NULL;
									end else if (neg_q && acc_q != '0) begin
										do_fail = 1'b1;
										f_code = ERR_LENGTH;
									end else if (acc_q > {34'b0, cfg.bulk_limit}) begin
										do_fail = 1'b1;
										f_code = ERR_BULK;
									end else begin
										n_brem = acc_q[29:0];
										n_neg = 1'b0;
										n_digit = 1'b0;
										n_held = 1'b0;
										n_bad = (ctype_q == VK_VERB) && (acc_q < 64'd4);
										n_phase = (acc_q != '0) ? PH_DATA : PH_DCR;
									end
								end
								VK_ARRAY, VK_MAP, VK_SET, VK_PUSH, VK_ATTR: begin
									if (!ok) begin
										do_fail = 1'b1;
										f_code = ERR_LENGTH;
									end else if (ctype_q == VK_ARRAY && neg_q && acc_q == 64'd1) begin
										do_finish = 1'b1;
										fin_vk = VK_NULL;
									end else if (neg_q && acc_q != '0) begin
										do_fail = 1'b1;
										f_code = ERR_LENGTH;
									end else if (n64 > {32'b0, cfg.element_limit}) begin
										do_fail = 1'b1;
										f_code = ERR_ELEMS;
									end else if ((depth_q + 1'b1) > eff) begin
										do_fail = 1'b1;
										f_code = ERR_DEPTH;
									end else begin
										do_open = 1'b1;
									end
								end
								default: begin
									do_fail = 1'b1;
									f_code = ERR_TYPE;
								end
							endcase
						end else begin
							if (is_text) begin
								// text leaves one byte late so the closing CR never shows
								if (held_q) begin
									ev_go = 1'b1;
									n_ev_kind = EV_PAYLOAD;
									n_vk = ctype_q;
									n_pay = acc_q[7:0];
									n_num = '0;
									n_dep = depth_q;
									n_closed = '0;
									n_done = 1'b0;
									n_disc = in_disc;
									n_err = '0;
									if (ctype_q == VK_BIGNUM
											&& !(llen_q == '0
											&& (acc_q[7:0] == CH_PLUS || acc_q[7:0] == CH_MINUS))) begin
										if (acc_q[7:0] >= CH_0 && acc_q[7:0] <= CH_9) begin
											n_digit = 1'b1;
										end else begin
											n_bad = 1'b1;
										end
									end
									l1 = llen_q + 1'b1;
								end
								n_acc = {56'b0, b};
								n_held = 1'b1;
							end else begin
								n_held = 1'b0;
								if (held_q) begin
									// a held CR that was not a line end counts as text
									if (ctype_q == VK_BOOL && l1 == '0) begin
										s.acc = {56'b0, CH_CR};
									end else if (ctype_q != VK_UNKNOWN) begin
										s.bad = 1'b1;
									end
									l1 = l1 + 1'b1;
								end
								if (b == CH_CR) begin
									n_held = 1'b1;
								end else begin
									s = numeric_char(s, ctype_q, l1, b);
									l1 = l1 + 1'b1;
								end
								n_acc = s.acc;
								n_neg = s.neg;
								n_digit = s.digit;
								n_bad = s.bad;
							end
							n_llen = l1;
							if (l1 >= LLEN_W'(LINE_MAX)) begin
								do_fail = 1'b1;
								f_code = ERR_LINE;
							end
						end
					end
					PH_DATA: begin
						if (ctype_q == VK_VERB && (acc_q[29:0] - brem_q) == 30'd3 && b != CH_COLON) begin
							n_bad = 1'b1;
						end
						n_brem = (brem_q != '0) ? brem_q - 1'b1 : brem_q;
						if (n_brem == '0) begin
							n_phase = PH_DCR;
						end
						ev_go = 1'b1;
						n_ev_kind = EV_PAYLOAD;
						n_vk = ctype_q;
						n_pay = b;
						n_num = '0;
						n_dep = depth_q;
						n_closed = '0;
						n_done = 1'b0;
						n_disc = in_disc;
						n_err = '0;
					end
					PH_DCR: begin
						if (b != CH_CR) begin
							do_fail = 1'b1;
							f_code = ERR_CRLF;
						end else begin
							n_phase = PH_DLF;
						end
					end
					PH_DLF: begin
						if (b != CH_LF) begin
							do_fail = 1'b1;
							f_code = ERR_CRLF;
						end else if (ctype_q == VK_VERB && bad_q) begin
							do_fail = 1'b1;
							f_code = ERR_VERB;
						end else begin
							do_finish = 1'b1;
						end
					end
					default: n_phase = PH_TYPE;
				endcase
				if ((do_finish || do_open) && n_rb > {1'b0, cfg.reply_limit}) begin
					do_fail = 1'b1;
					f_code = ERR_REPLY;
				end
			end

			n_closed = '0;
			n_done = 1'b0;
			if (do_fail) begin
				n_failed = 1'b1;
				ev_go = 1'b1;
				n_ev_kind = EV_ERROR;
				n_vk = '0;
				n_pay = '0;
				n_num = '0;
				n_dep = depth_q;
				n_disc = 1'b0;
				n_err = f_code;
			end else if (do_finish) begin
				settle_go = 1'b1;
				n_deliver = 1'b1;
				n_phase = PH_TYPE;
				n_ev_kind = EV_COMPLETE;
				n_vk = fin_vk;
				n_pay = '0;
				n_num = fin_num;
				n_dep = depth_q;
				n_disc = in_disc;
				n_err = '0;
			end else if (do_open) begin
				settle_go = 1'b1;
				n_deliver = 1'b0;
				n_phase = PH_TYPE;
				fr_we = 1'b1;
				ft_we = 1'b1;
				fr_addr = depth_q[IDX_W-1:0];
				fr_rem = n64[FREM_W-1:0];
				n_depth = depth_q + 1'b1;
				n_ev_kind = EV_OPEN;
				n_vk = ctype_q;
				n_pay = '0;
				n_num = acc_q;
				n_dep = depth_q;
				n_disc = in_disc || (ctype_q == VK_ATTR) || (ctype_q == VK_PUSH && depth_q == '0);
				n_err = '0;
			end
			if (ev_go) begin
				n_ev_valid = 1'b1;
			end
		end
	end

	// frame stack, written before it is read
	always_ff @(posedge clk) begin
		if (fr_we) begin
			frem_q[fr_addr] <= fr_rem;
		end
		if (ft_we) begin
			ftype_q[fr_addr] <= ft_type;
		end
	end

	always_ff @(posedge clk) begin
		pay_q <= n_pay;
		num_q <= n_num;
		vk_q <= n_vk;
		ev_kind_q <= n_ev_kind;
		dep_q <= n_dep;
		closed_q <= n_closed;
		done_q <= n_done;
		disc_q <= n_disc;
		err_q <= n_err;
		acc_q <= n_acc;
		brem_q <= n_brem;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_BYTE;
			phase_q <= PH_TYPE;
			ctype_q <= '0;
			llen_q <= '0;
			neg_q <= 1'b0;
			digit_q <= 1'b0;
			bad_q <= 1'b0;
			held_q <= 1'b0;
			depth_q <= '0;
			rbytes_q <= '0;
			failed_q <= 1'b0;
			deliver_q <= 1'b0;
			ev_valid_q <= 1'b0;
		end else begin
			state_q <= n_state;
			phase_q <= n_phase;
			ctype_q <= n_ctype;
			llen_q <= n_llen;
			neg_q <= n_neg;
			digit_q <= n_digit;
			bad_q <= n_bad;
			held_q <= n_held;
			depth_q <= n_depth;
			rbytes_q <= n_rb;
			failed_q <= n_failed;
			deliver_q <= n_deliver;
			ev_valid_q <= n_ev_valid;
		end
	end

	assign event_valid = ev_valid_q;
	assign event_kind = ev_kind_q;
	assign value_kind = vk_q;
	assign payload = pay_q;
	assign number = num_q;
	assign depth = dep_q;
	assign levels_closed = closed_q;
	assign reply_done = done_q;
	assign discarded = disc_q;
	assign error_code = err_q;

endmodule

### hdl/resp3_reply_stream_parser.sv
`timescale 1ns / 1ps
// Flow: a byte is registered in the input queue, then the parser takes it and registers its
// event; complete and open events come from the settle step once it has closed levels.
// Throughput: one byte per cycle while the event output is not stalled and no settle runs.
// Reset clears the queue, parser state, stack depth and error flag, and loads the limit
// registers with their defaults; the frame stack is not cleared.
module resp3_reply_stream_parser (
	input logic clk,
	input logic arst_n,
	input logic byte_valid,
	output logic byte_stall,
	input logic [7:0] data_byte,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [1:0] cfg_index,
	input logic [31:0] cfg_data,
	output logic event_valid,
	input logic event_stall,
	output logic [1:0] event_kind,
	output logic [3:0] value_kind,
	output logic [7:0] payload,
	output logic signed [63:0] number,
	output logic [5:0] depth,
	output logic [5:0] levels_closed,
	output logic reply_done,
	output logic discarded,
	output logic [3:0] error_code
);
	import rrsp_pkg::*;

	cfg_t cfg_q;
	logic item_valid;
	item_t item;
	logic item_pop;
	logic [63:0] number_raw;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bulk_limit <= 30'd536870912;
			cfg_q.element_limit <= 32'd1048576;
			cfg_q.depth_limit <= 6'd32;
			cfg_q.reply_limit <= 32'hFFFF_FFFF;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_BULK: cfg_q.bulk_limit <= cfg_data[29:0];
				REG_ELEMS: cfg_q.element_limit <= cfg_data;
				REG_DEPTH: cfg_q.depth_limit <= cfg_data[5:0];
				REG_REPLY: cfg_q.reply_limit <= cfg_data;
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	rrsp_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.byte_valid(byte_valid),
		.byte_stall(byte_stall),
		.data_byte(data_byte),
		.item_valid(item_valid),
		.item(item),
		.item_pop(item_pop)
	);

	rrsp_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.item_valid(item_valid),
		.item(item),
		.item_pop(item_pop),
		.event_valid(event_valid),
		.event_stall(event_stall),
		.event_kind(event_kind),
		.value_kind(value_kind),
		.payload(payload),
		.number(number_raw),
		.depth(depth),
		.levels_closed(levels_closed),
		.reply_done(reply_done),
		.discarded(discarded),
		.error_code(error_code)
	);

	assign number = $signed(number_raw);

`ifndef SYNTHESIS
	a_payload_no_close: assert property (@(posedge clk) disable iff (!arst_n)
		event_valid && (event_kind == EV_PAYLOAD || event_kind == EV_ERROR)
		|-> levels_closed == '0 && !reply_done)
		else $error("payload or error event closes levels");
	a_done_kind: assert property (@(posedge clk) disable iff (!arst_n)
		event_valid && reply_done |-> event_kind == EV_COMPLETE || event_kind == EV_OPEN)
		else $error("reply done on wrong event kind");
	a_depth_range: assert property (@(posedge clk) disable iff (!arst_n)
		event_valid |-> depth <= 6'(MAX_DEPTH) && levels_closed <= 6'(MAX_DEPTH))
		else $error("depth out of range");
	a_sticky_fail: assert property (@(posedge clk) disable iff (!arst_n)
		event_valid && !event_stall && event_kind == EV_ERROR |=> !event_valid
		|| event_kind == EV_ERROR)
		else $error("event after error is not an error");
`endif

endmodule
